// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hw/rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants and item types of the increasing subsequence length core.
// ----------------------------------------------------------------------------
`default_nettype none

package lis_pkg;

  localparam int unsigned MAX_LEN_DEF    = 1024;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned VALUE_W        = 16;
  localparam int unsigned LENGTH_W       = 11;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } lis_in_t;

  typedef struct packed {
    logic [LENGTH_W-1:0] length;
    logic                overflow;
  } lis_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/lis_ram.sv
// ----------------------------------------------------------------------------
// lis_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/lis_cell.sv
// ----------------------------------------------------------------------------
// lis_cell
// One level of the tail search: owns the tails probed at its level, compares
// one against the value and hands the refined position to the next level.
// ----------------------------------------------------------------------------
`default_nettype none

module lis_cell #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned LEVEL      = 0,
  localparam int unsigned LEVELS    = $clog2(MAX_LEN + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [LEVELS-1:0]     in_pos_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic [LEVELS-1:0]     count_i,
  input  wire logic                  wr_en_i,
  input  wire logic [LEVELS-1:0]     wr_idx_i,
  output logic                       out_valid_o,
  output logic      [LEVELS-1:0]     out_pos_o
);

  localparam int unsigned DEPTH  = 2 ** (LEVELS - 1 - LEVEL);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEVELS-1:0] STEP     = LEVELS'(2 ** LEVEL);
  localparam logic [LEVELS-1:0] OFFSET   = LEVELS'(2 ** LEVEL - 1);
  localparam logic [LEVELS-1:0] LOW_MASK = LEVELS'(2 ** (LEVEL + 1) - 1);

  logic                  valid_q;
  logic [LEVELS-1:0]     pos_q;
  logic [LEVELS-1:0]     rd_shift;
  logic [LEVELS-1:0]     wr_shift;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;
  logic                  wr_here;
  logic [VALUE_BITS-1:0] tail;
  logic [LEVELS-1:0]     probe_idx;
  logic                  take;

  assign rd_shift = in_pos_i >> (LEVEL + 1);
  assign wr_shift = wr_idx_i >> (LEVEL + 1);
  assign raddr    = rd_shift[ADDR_W-1:0];
  assign waddr    = wr_shift[ADDR_W-1:0];
  assign wr_here  = wr_en_i && ((wr_idx_i & LOW_MASK) == OFFSET);

  lis_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_here),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= in_pos_i;
  end

  // entries at or beyond the count behave as larger than any value
  assign probe_idx   = pos_q + OFFSET;
  assign take        = (probe_idx < count_i) && (tail < value_i);
  assign out_valid_o = valid_q;
  assign out_pos_o   = take ? (pos_q | STEP) : pos_q;

endmodule

`default_nettype wire

// File: hw/rtl/longest_increasing_subsequence_length_core.sv
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length_core
// Streams values and reports the longest strictly increasing subsequence
// length so far, by patience sorting over a table of tails.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An accepted item runs a lower-bound search
// down a chain of clog2(MAX_LEN+1) cells, one search level per cycle, each cell
// reading its own RAM of tails with a registered read; the table update and the
// result register load follow once the last cell finishes and the result
// register is free. A new item is therefore accepted only after the previous
// one is complete, and a result left waiting holds the next item back. The
// input is taken while an earlier result still waits. The tail RAMs need no
// clearing: only entries below the current length are ever used, and the last
// flag of an item resets the length and the overflow flag after its result.
`default_nettype none

`include "assert_macros.svh"

module longest_increasing_subsequence_length_core
  import lis_pkg::*;
#(
  parameter int unsigned MAX_LEN    = MAX_LEN_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire lis_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output lis_out_t      out_data_o
);

  localparam int unsigned LEVELS = $clog2(MAX_LEN + 1);
  localparam logic [LEVELS-1:0] MAX_COUNT = LEVELS'(MAX_LEN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_HOLD
  } state_e;

  state_e                state_q;
  logic                  out_valid_q;
  lis_out_t              out_q;
  logic [LEVELS-1:0]     count_q;
  logic                  ovf_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  last_q;
  logic [LEVELS-1:0]     hold_pos_q;

  logic                  in_acc;
  logic                  tok_valid [LEVELS+1];
  logic [LEVELS-1:0]     tok_pos   [LEVELS+1];
  logic [LEVELS:0]       tok_valid_vec;
  logic                  out_free;
  logic                  complete;
  logic [LEVELS-1:0]     fin_pos;
  logic                  hit;
  logic                  room;
  logic                  wr_en;
  logic [LEVELS-1:0]     wr_idx;
  logic [LEVELS-1:0]     count_new;
  logic                  ovf_new;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign tok_valid[LEVELS] = in_acc;
  assign tok_pos[LEVELS]   = '0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    lis_cell #(
      .MAX_LEN    (MAX_LEN),
      .VALUE_BITS (VALUE_BITS),
      .LEVEL      (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (tok_valid[g+1]),
      .in_pos_i    (tok_pos[g+1]),
      .value_i     (value_q),
      .count_i     (count_q),
      .wr_en_i     (wr_en),
      .wr_idx_i    (wr_idx),
      .out_valid_o (tok_valid[g]),
      .out_pos_o   (tok_pos[g])
    );
  end

  always_comb begin
    for (int i = 0; i <= LEVELS; i++) begin
      tok_valid_vec[i] = tok_valid[i];
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign fin_pos   = (state_q == S_HOLD) ? hold_pos_q : tok_pos[0];
  assign complete  = out_free &&
                     (((state_q == S_SEARCH) && tok_valid[0]) || (state_q == S_HOLD));
  assign hit       = fin_pos < count_q;
  assign room      = count_q < MAX_COUNT;
  assign wr_en     = complete && (hit || room);
  assign wr_idx    = hit ? fin_pos : count_q;
  assign count_new = (!hit && room) ? (count_q + 1'b1) : count_q;
  assign ovf_new   = ovf_q || (!hit && !room);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (complete) begin
        out_valid_q    <= 1'b1;
        out_q.length   <= LENGTH_W'(count_new);
        out_q.overflow <= ovf_new;
        count_q        <= last_q ? '0 : count_new;
        ovf_q          <= last_q ? 1'b0 : ovf_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tok_valid[0]) begin
            state_q <= complete ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (complete) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      value_q <= VALUE_BITS'(in_data_i.value);
      last_q  <= in_data_i.last;
    end
    if ((state_q == S_SEARCH) && tok_valid[0]) begin
      hold_pos_q <= tok_pos[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_single_token, clk_i, rst_ni, $onehot0(tok_valid_vec), "more than one search in flight")
  `ASSERT_IMPLIES(a_search_latency, clk_i, rst_ni, in_acc, ##LEVELS tok_valid[0], "search did not finish on time")
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= MAX_COUNT, "length beyond table capacity")
  `ASSERT_IMPLIES(a_hold_no_token, clk_i, rst_ni, state_q == S_HOLD, !tok_valid_vec[0], "token arrived while holding a result")

endmodule

`default_nettype wire

// File: verif/lis_length_checker.sv
// ----------------------------------------------------------------------------
// lis_length_checker
// Watches both item channels of the increasing subsequence length core. It
// keeps its own table of tails, predicts the length and overflow flag of every
// accepted input item and compares them with the results in order.
// ----------------------------------------------------------------------------
module lis_length_checker
  import lis_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  lis_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  lis_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VALUE_W-1:0] tails [MAX_LEN_DEF];
  int unsigned        run_length = 0;
  logic               drop_seen  = 1'b0;
  lis_out_t           lengths_due [$];
  int                 errors     = 0;

  function automatic lis_out_t extend_tails(lis_in_t item);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lis_out_t    res;
    lo = 0;
    hi = run_length;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (tails[mid] < item.value) lo = mid + 1;
      else hi = mid;
    end
    if (lo < run_length) begin
      tails[lo] = item.value;
    end else if (run_length < MAX_LEN_DEF) begin
      tails[run_length] = item.value;
      run_length++;
    end else begin
      drop_seen = 1'b1;
    end
    res.length   = LENGTH_W'(run_length);
    res.overflow = drop_seen;
    if (item.last) begin
      run_length = 0;
      drop_seen  = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lis_out_t due;
    if (!rst_ni) begin
      lengths_due.delete();
      run_length = 0;
      drop_seen  = 1'b0;
      errors     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (lengths_due.size() == 0) begin
          $error("length: expected none, got %0d", out_data_i.length);
          errors++;
        end else begin
          due = lengths_due.pop_front();
          if (out_data_i.length !== due.length) begin
            $error("length: expected %0d, got %0d", due.length, out_data_i.length);
            errors++;
          end
          if (out_data_i.overflow !== due.overflow) begin
            $error("overflow: expected %0b, got %0b", due.overflow, out_data_i.overflow);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) lengths_due.push_back(extend_tails(in_data_i));
      fail_count_o <= errors;
      pending_o    <= lengths_due.size();
    end
  end

endmodule

// File: verif/tb_longest_increasing_subsequence_length_core.sv
// ----------------------------------------------------------------------------
// tb_longest_increasing_subsequence_length_core
// Drives value sequences into the core with random gaps on both channels:
// edge values and repeats first, then noisy, narrow, rising and falling
// sequences and one ramp long enough to fill the table. The checker beside the
// core predicts every result; the verdict follows once all results are in.
// ----------------------------------------------------------------------------
module tb_longest_increasing_subsequence_length_core;
  import lis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS    = 1700;
  localparam int RAMP_START_AT  = 300;
  localparam int RAMP_RISES     = 1030;
  localparam int RAMP_TAIL      = 10;
  localparam int HOLD_AT        = 120;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING
  } seq_shape_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  lis_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  lis_out_t out_data_o;
  int       fails;
  int       pending;
  int       sent        = 0;
  int       tx_calm     = 0;
  int       rx_calm     = 0;
  int       quiet       = 0;

  longest_increasing_subsequence_length_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  lis_length_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic send_item(input logic [VALUE_W-1:0] v, input logic l);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= lis_in_t'{value: v, last: l};
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // receiver
  initial begin
    int hold;
    int taken;
    taken = 0;
    @(posedge clk_i iff rst_ni);
    forever begin
      hold = (taken == HOLD_AT) ? LONG_HOLD : draw_gap(rx_calm);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("longest_increasing_subsequence_length_core: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [VALUE_W-1:0] v;
    seq_shape_e         shape;
    int                 seq_len;
    bit                 ramp_done;
    ramp_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(16'h0000, 1'b1);
    send_item(16'hFFFF, 1'b1);
    send_item(16'd5, 1'b0);
    send_item(16'd5, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(16'd7, 1'b0);
    send_item(16'd7, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0001, 1'b1);
    send_item(16'h0001, 1'b0);
    send_item(16'h0002, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'hFFFE, 1'b0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h00FF, 1'b0);
    send_item(16'h0000, 1'b1);
    drain_results();

    while (sent < TOTAL_ITEMS) begin
      if (!ramp_done && sent >= RAMP_START_AT) begin
        // fill the table, then push past capacity
        v = VALUE_W'($urandom_range(0, 100));
        for (int k = 0; k < RAMP_RISES + RAMP_TAIL; k++) begin
          if (k < RAMP_RISES) v = v + VALUE_W'($urandom_range(1, 62));
          else if (k == RAMP_RISES + 2) v = 16'hFFFF;
          else v = VALUE_W'($urandom);
          send_item(v, k == RAMP_RISES + RAMP_TAIL - 1);
        end
        ramp_done = 1'b1;
      end else begin
        shape   = seq_shape_e'($urandom_range(0, 3));
        seq_len = $urandom_range(1, 40);
        v       = VALUE_W'($urandom);
        for (int k = 0; k < seq_len; k++) begin
          case (shape)
            SHAPE_NOISE: begin
              v = VALUE_W'($urandom);
            end
            SHAPE_NARROW: begin
              v = VALUE_W'($urandom_range(0, 15));
            end
            SHAPE_RISING: begin
              if ($urandom_range(0, 7) == 0) v = v - VALUE_W'($urandom_range(0, 2000));
              else v = v + VALUE_W'($urandom_range(0, 300));
            end
            default: begin
              if ($urandom_range(0, 7) == 0) v = v + VALUE_W'($urandom_range(0, 2000));
              else v = v - VALUE_W'($urandom_range(0, 300));
            end
          endcase
          send_item(v, k == seq_len - 1);
        end
        if ($urandom_range(0, 24) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("longest_increasing_subsequence_length_core: match");
    end else begin
      $display("longest_increasing_subsequence_length_core: mismatch");
    end
    $finish;
  end

endmodule
